### rtl/rolling_hash_pattern_match_top_defines.svh
// Assertion macros for the rolling hash pattern matcher.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef ROLLING_HASH_PATTERN_MATCH_TOP_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RHPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RHPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RHPM_ASSERT_IMP(lbl, ante, cons, msg)

`define RHPM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/rhpm_pkg.sv
// Shared types and constants for the rolling hash pattern matcher.
// No dependencies; used by rhpm_mod_unit, the top level and the testbench.
package rhpm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam longint unsigned TEXT_MAX = 64'd65536;
    localparam logic [15:0] POS_CAP =
        (TEXT_MAX - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(TEXT_MAX - 64'd1);

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_PAT0 = 3'd0;
    localparam logic [2:0] REG_PAT1 = 3'd1;
    localparam logic [2:0] REG_PAT2 = 3'd2;
    localparam logic [2:0] REG_PAT3 = 3'd3;
    localparam logic [2:0] REG_LEN  = 3'd4;
    localparam logic [2:0] REG_MOD  = 3'd5;

    localparam logic [5:0]  LEN_RESET = 6'd1;
    localparam logic [15:0] MOD_RESET = 16'd101;
    localparam logic [15:0] MOD_MIN   = 16'd2;

    localparam int STEPS_W = 5;
    localparam logic [STEPS_W-1:0] STEPS_BYTE = 5'd8;
    localparam logic [STEPS_W-1:0] STEPS_PROD = 5'd24;

    typedef struct packed {
        logic               start;
        logic [15:0]        init;
        logic [23:0]        src;
        logic [STEPS_W-1:0] steps;
    } rhpm_op_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] value;
    } rhpm_res_t;

endpackage

### rtl/rhpm_mod_unit.sv
// Bit-serial modular reducer: shifts source bits into a remainder, one per cycle.
// Depends on rhpm_pkg.
module rhpm_mod_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  rhpm_pkg::rhpm_op_t  op,
    input  logic [15:0]         modulus,
    output rhpm_pkg::rhpm_res_t res
);
    import rhpm_pkg::*;

    logic [15:0]        rem_reg;
    logic [23:0]        src_reg;
    logic [STEPS_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [16:0]        shifted;
    logic [16:0]        reduced;

    // remainder stays below modulus, so one conditional subtract per bit
    assign shifted = {rem_reg, src_reg[23]};
    assign reduced = (shifted >= {1'b0, modulus}) ? shifted - {1'b0, modulus} : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (op.start)
        begin
            cnt_reg  <= op.steps;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEPS_W'(1);
            if (cnt_reg == STEPS_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.start)
        begin
            rem_reg <= op.init;
            src_reg <= op.src;
        end
        else if (busy_reg)
        begin
            rem_reg <= reduced[15:0];
            src_reg <= {src_reg[22:0], 1'b0};
        end
    end

    assign res.busy  = busy_reg;
    assign res.done  = done_reg;
    assign res.value = rem_reg;

endmodule

### rtl/rolling_hash_pattern_match_top.sv
// Rolling hash pattern matcher, top level: APB registers, sequencer, window.
// Depends on rhpm_pkg, rhpm_mod_unit and rolling_hash_pattern_match_top_defines.svh.
//
// Usage:
//   Text bytes enter on the input channel (text_char, end_of_text) under
//   in_valid/in_ready; results leave on the output channel under
//   out_valid/out_ready. A byte gives a result only when a true pattern
//   occurrence ends on it; end_of_text always gives one result with the count.
//   The user writes pattern, length and modulus over the APB port while
//   idle; the block does not enforce this. Bytes are taken one at a time.
//   A byte with a full window first reduces the outgoing-byte product, then
//   updates the hash; when the hashes agree the pattern bytes are compared
//   one by one and a match is then emitted; a partly filled window skips the
//   product. The first byte of a text first computes the leading weight and
//   then the pattern hash. All modular work runs through one bit-serial
//   reducer, one bit a cycle, for the 24-bit product and each Horner byte.
//   Reset: pattern zero, length 1, modulus 101, text state cleared.
//   A stalled receiver holds the result in the output register; the block
//   takes the next byte meanwhile and waits only when a second result is due.
`include "rolling_hash_pattern_match_top_defines.svh"

module rolling_hash_pattern_match_top #(
    parameter int PATTERN_MAX = rhpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rhpm_pkg::ADDR_W-1:0]   paddr,
    input  logic [rhpm_pkg::DATA_W-1:0]   pwdata,
    output logic [rhpm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_char,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          match_found,
    output logic [15:0]                   match_start,
    output logic [15:0]                   match_total,
    output logic                          text_done
);
    import rhpm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LW, ST_LW_W, ST_PH, ST_PH_W, ST_SUB, ST_SUB_W,
        ST_DIFF, ST_HASH, ST_HASH_W, ST_CMP, ST_EMIT
    } state_t;

    // configuration registers
    logic [63:0] pat_reg [4];
    logic [5:0]  pat_len_reg;
    logic [15:0] modulus_reg;

    // text state
    state_t             state_reg;
    logic [7:0]         window_reg [PATTERN_MAX];
    logic [7:0]         char_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [15:0]        mod_act_reg;
    logic [15:0]        lw_reg;
    logic [15:0]        ph_reg;
    logic [15:0]        text_hash_reg;
    logic [15:0]        sub_reg;
    logic [15:0]        pos_reg;
    logic [15:0]        here_reg;
    logic [15:0]        count_reg;
    logic [LEN_W-1:0]   fill_reg;
    logic [LEN_W-1:0]   k_reg;

    // pending and output results
    logic               res_found_reg;
    logic [15:0]        res_start_reg;
    logic [15:0]        res_total_reg;
    logic               res_done_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [15:0]        out_start_reg;
    logic [15:0]        out_total_reg;
    logic               out_done_reg;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [255:0]       pat_flat;
    logic [4:0]         pat_k;
    logic [7:0]         pat_byte;
    logic [IDX_W-1:0]   win_idx;
    logic [7:0]         win_rd;
    logic [23:0]        sub_prod;
    logic [LEN_W-1:0]   len_m1;
    logic [LEN_W-1:0]   len_cfg;
    logic [15:0]        mod_cfg;
    logic [LEN_W-1:0]   fill_inc;
    logic [15:0]        here_m1;
    logic [15:0]        diff;
    logic               lw_more;
    logic               ph_more;
    logic               fill_full;
    logic               out_free;
    rhpm_op_t           eng_op;
    rhpm_res_t          eng_res;

    // APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (cfg_idx)
            REG_PAT0: prdata = pat_reg[0];
            REG_PAT1: prdata = pat_reg[1];
            REG_PAT2: prdata = pat_reg[2];
            REG_PAT3: prdata = pat_reg[3];
            REG_LEN:  prdata = 64'(pat_len_reg);
            REG_MOD:  prdata = 64'(modulus_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg[0]  <= '0;
            pat_reg[1]  <= '0;
            pat_reg[2]  <= '0;
            pat_reg[3]  <= '0;
            pat_len_reg <= LEN_RESET;
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_PAT0: pat_reg[0]  <= pwdata;
                REG_PAT1: pat_reg[1]  <= pwdata;
                REG_PAT2: pat_reg[2]  <= pwdata;
                REG_PAT3: pat_reg[3]  <= pwdata;
                REG_LEN:  pat_len_reg <= pwdata[5:0];
                REG_MOD:  modulus_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    // helpers
    assign pat_flat = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};
    assign pat_k    = 5'(k_reg);
    assign pat_byte = pat_flat[{pat_k, 3'b000} +: 8];

    assign len_m1  = len_reg - LEN_W'(1);
    assign win_idx = (state_reg == ST_CMP) ? IDX_W'(len_m1 - k_reg) : IDX_W'(len_m1);
    assign win_rd  = window_reg[win_idx];
    assign sub_prod = 24'(win_rd) * 24'(lw_reg);

    always_comb
    begin
        priority if (pat_len_reg == 6'd0)
            len_cfg = LEN_W'(1);
        else if (pat_len_reg > 6'(PATTERN_MAX))
            len_cfg = LEN_MAX;
        else
            len_cfg = LEN_W'(pat_len_reg);
    end

    assign mod_cfg   = (modulus_reg < MOD_MIN) ? MOD_MIN : modulus_reg;
    assign fill_inc  = (fill_reg < LEN_MAX) ? fill_reg + LEN_W'(1) : fill_reg;
    assign here_m1   = 16'(len_m1);
    assign lw_more   = k_reg < len_m1;
    assign ph_more   = k_reg < len_reg;
    assign fill_full = fill_reg >= len_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign diff = (text_hash_reg >= sub_reg) ? text_hash_reg - sub_reg
                : 16'(({1'b0, text_hash_reg} + {1'b0, mod_act_reg}) - {1'b0, sub_reg});

    // reducer commands
    always_comb
    begin
        eng_op = '0;
        unique case (state_reg)
            ST_LW:
            begin
                eng_op.start = lw_more;
                eng_op.init  = lw_reg;
                eng_op.src   = '0;
                eng_op.steps = STEPS_BYTE;
            end
            ST_PH:
            begin
                eng_op.start = ph_more;
                eng_op.init  = ph_reg;
                eng_op.src   = {pat_byte, 16'h0000};
                eng_op.steps = STEPS_BYTE;
            end
            ST_SUB:
            begin
                eng_op.start = fill_full;
                eng_op.init  = '0;
                eng_op.src   = sub_prod;
                eng_op.steps = STEPS_PROD;
            end
            ST_HASH:
            begin
                eng_op.start = 1'b1;
                eng_op.init  = text_hash_reg;
                eng_op.src   = {char_reg, 16'h0000};
                eng_op.steps = STEPS_BYTE;
            end
            default: ;
        endcase
    end

    rhpm_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (eng_op),
        .modulus (mod_act_reg),
        .res     (eng_res)
    );

    // window shift line
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_HASH_W && eng_res.done)
        begin
            for (int i = PATTERN_MAX - 1; i > 0; i--)
                window_reg[i] <= window_reg[i-1];
            window_reg[0] <= char_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            char_reg      <= '0;
            len_reg       <= LEN_W'(1);
            mod_act_reg   <= MOD_RESET;
            lw_reg        <= 16'd1;
            ph_reg        <= '0;
            text_hash_reg <= '0;
            sub_reg       <= '0;
            pos_reg       <= '0;
            here_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            res_found_reg <= 1'b0;
            res_start_reg <= '0;
            res_total_reg <= '0;
            res_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
            out_total_reg <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (end_of_text)
                        begin
                            res_found_reg <= 1'b0;
                            res_start_reg <= '0;
                            res_total_reg <= count_reg;
                            res_done_reg  <= 1'b1;
                            pos_reg       <= '0;
                            fill_reg      <= '0;
                            text_hash_reg <= '0;
                            count_reg     <= '0;
                            state_reg     <= ST_EMIT;
                        end
                        else
                        begin
                            char_reg <= text_char;
                            if (pos_reg == 16'd0 && fill_reg == '0)
                            begin
                                len_reg     <= len_cfg;
                                mod_act_reg <= mod_cfg;
                                lw_reg      <= 16'd1;
                                ph_reg      <= '0;
                                k_reg       <= '0;
                                state_reg   <= ST_LW;
                            end
                            else
                            begin
                                state_reg <= ST_SUB;
                            end
                        end
                    end
                end
                ST_LW:
                begin
                    if (lw_more)
                    begin
                        state_reg <= ST_LW_W;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_PH;
                    end
                end
                ST_LW_W:
                begin
                    if (eng_res.done)
                    begin
                        lw_reg    <= eng_res.value;
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= ST_LW;
                    end
                end
                ST_PH:
                begin
                    state_reg <= ph_more ? ST_PH_W : ST_SUB;
                end
                ST_PH_W:
                begin
                    if (eng_res.done)
                    begin
                        ph_reg    <= eng_res.value;
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= ST_PH;
                    end
                end
                ST_SUB:
                begin
                    state_reg <= fill_full ? ST_SUB_W : ST_HASH;
                end
                ST_SUB_W:
                begin
                    if (eng_res.done)
                    begin
                        sub_reg   <= eng_res.value;
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    text_hash_reg <= diff;
                    state_reg     <= ST_HASH;
                end
                ST_HASH:
                begin
                    state_reg <= ST_HASH_W;
                end
                ST_HASH_W:
                begin
                    if (eng_res.done)
                    begin
                        text_hash_reg <= eng_res.value;
                        fill_reg      <= fill_inc;
                        here_reg      <= pos_reg;
                        if (pos_reg < POS_CAP)
                            pos_reg <= pos_reg + 16'd1;
                        k_reg <= '0;
                        if (fill_inc >= len_reg && eng_res.value == ph_reg)
                            state_reg <= ST_CMP;
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_CMP:
                begin
                    if (win_rd != pat_byte)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (k_reg == len_m1)
                    begin
                        res_found_reg <= 1'b1;
                        res_start_reg <= (here_reg >= here_m1) ? here_reg - here_m1 : '0;
                        res_total_reg <= (count_reg != 16'hFFFF) ? count_reg + 16'd1
                                                                 : count_reg;
                        res_done_reg  <= 1'b0;
                        if (count_reg != 16'hFFFF)
                            count_reg <= count_reg + 16'd1;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + LEN_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= res_found_reg;
                        out_start_reg <= res_start_reg;
                        out_total_reg <= res_total_reg;
                        out_done_reg  <= res_done_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign match_found = out_found_reg;
    assign match_start = out_start_reg;
    assign match_total = out_total_reg;
    assign text_done   = out_done_reg;

    `RHPM_ASSERT_IMP(a_idle_unit_quiet, state_reg == ST_IDLE, !eng_res.busy, "reducer busy while idle")
    `RHPM_ASSERT_IMP(a_hash_in_range, 1'b1, (text_hash_reg < mod_act_reg) && (lw_reg < mod_act_reg) && (ph_reg < mod_act_reg), "hash state not reduced")
    `RHPM_ASSERT_IMP(a_match_counted, out_valid && match_found, !text_done && match_total != 16'd0, "match result without count")
    `RHPM_ASSERT_NXT(a_sub_launch, state_reg == ST_SUB && fill_full, eng_res.busy, "product reduction not started")

endmodule

### tb/rolling_hash_pattern_match_top_tb.sv
// Self-checking testbench for rolling_hash_pattern_match_top: pattern set-up over APB,
// text bytes with random handshake gaps, results checked against a behavioural scan.
// Depends on rhpm_pkg and the RTL of rolling_hash_pattern_match_top.
module rolling_hash_pattern_match_top_tb;
    import rhpm_pkg::*;

    localparam int QUIET_CYCLES = 1000;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 800;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_token_t;

    typedef struct packed {
        logic        found;
        logic [15:0] start;
        logic [15:0] total;
        logic        done;
    } match_res_t;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        text_char = '0;
    logic              end_of_text = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              match_found;
    logic [15:0]       match_start;
    logic [15:0]       match_total;
    logic              text_done;

    text_token_t text_queue[$];
    match_res_t  due_matches[$];
    int unsigned tokens_queued = 0;
    int unsigned tokens_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    // register copies
    logic [63:0] pat_word [4];
    logic [5:0]  pat_len_reg;
    logic [15:0] mod_reg;

    // scan state
    logic [7:0]  win [32];
    int unsigned txt_hash, pat_hash, lead_w, txt_pos, occ_cnt, fill, act_len, act_mod;

    // driver and receiver state
    text_token_t nxt_tok;
    match_res_t  pending;
    match_res_t  want;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold = 40;
    int unsigned stretch_left = 0;
    int unsigned rx_tick = 0;
    rx_mode_t    rx_mode = RX_FREE;

    rolling_hash_pattern_match_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_found (match_found),
        .match_start (match_start),
        .match_total (match_total),
        .text_done   (text_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_len(input logic [5:0] v);
        if (v == 0)
            return 1;
        if (v > PATTERN_MAX_DEF)
            return PATTERN_MAX_DEF;
        return 32'(v);
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned k);
        return pat_word[(k >> 3) & 3][8 * (k & 7) +: 8];
    endfunction

    function automatic void clear_text();
        foreach (win[i])
            win[i] = '0;
        txt_hash = 0;
        txt_pos  = 0;
        occ_cnt  = 0;
        fill     = 0;
    endfunction

    // Expected outcome of one text transaction; returns 1 when a result is due.
    function automatic bit scan_byte(input logic [7:0] c, input logic eot,
                                     output match_res_t r);
        int unsigned here;
        int unsigned k;
        bit          hit;
        r = '0;
        if (eot)
        begin
            r.total = occ_cnt[15:0];
            r.done  = 1'b1;
            clear_text();
            return 1'b1;
        end
        if (txt_pos == 0 && fill == 0)
        begin
            act_len = clamp_len(pat_len_reg);
            act_mod = 32'((mod_reg < MOD_MIN) ? MOD_MIN : mod_reg);
            lead_w  = 1 % act_mod;
            for (k = 0; k + 1 < act_len; k++)
                lead_w = (lead_w * 256) % act_mod;
            pat_hash = 0;
            for (k = 0; k < act_len; k++)
                pat_hash = (pat_hash * 256 + pat_byte(k)) % act_mod;
        end
        if (fill >= act_len)
            txt_hash = (txt_hash + act_mod - (win[act_len - 1] * lead_w) % act_mod) % act_mod;
        txt_hash = (txt_hash * 256 + c) % act_mod;
        for (k = 31; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = c;
        if (fill < 32)
            fill++;
        here = txt_pos;
        if (txt_pos < POS_CAP)
            txt_pos++;
        hit = (fill >= act_len) && (txt_hash == pat_hash);
        for (k = 0; hit && k < act_len; k++)
            if (win[act_len - 1 - k] != pat_byte(k))
                hit = 1'b0;
        if (!hit)
            return 1'b0;
        if (occ_cnt < 65535)
            occ_cnt++;
        r.found = 1'b1;
        r.start = (here >= act_len - 1) ? 16'(here - (act_len - 1)) : 16'd0;
        r.total = occ_cnt[15:0];
        return 1'b1;
    endfunction

    function automatic void add_token(input logic [7:0] c, input logic eot);
        text_queue.push_back('{c, eot});
        tokens_queued++;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LEN: pat_len_reg = val[5:0];
            REG_MOD: mod_reg = val[15:0];
            default: pat_word[idx[1:0]] = val;
        endcase
    endtask

    task automatic wait_drained();
        int unsigned n;
        n = 0;
        while ((tokens_taken != tokens_queued || due_matches.size() != 0) && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic random_config();
        logic [7:0]  pb [32];
        logic [7:0]  sym_a, sym_b;
        logic [63:0] w;
        logic [5:0]  len;
        logic [15:0] m;
        int unsigned r, wi, bi;
        bit          two_sym;
        two_sym = ($urandom_range(0, 9) < 6);
        sym_a   = 8'($urandom);
        sym_b   = 8'($urandom);
        foreach (pb[i])
            pb[i] = two_sym ? ($urandom_range(0, 1) ? sym_a : sym_b) : 8'($urandom);
        for (wi = 0; wi < 4; wi++)
        begin
            for (bi = 0; bi < 8; bi++)
                w[8 * bi +: 8] = pb[8 * wi + bi];
            reg_write(REG_PAT0 + 3'(wi), w);
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            len = 6'($urandom_range(1, 4));
        else if (r < 80)
            len = 6'($urandom_range(5, 12));
        else if (r < 93)
            len = 6'($urandom_range(13, 32));
        else if (r < 96)
            len = 6'd0;
        else
            len = 6'($urandom_range(33, 63));
        reg_write(REG_LEN, 64'(len));
        r = $urandom_range(0, 99);
        if (r < 20)
            m = MOD_MIN;
        else if (r < 30)
            m = 16'hFFFF;
        else if (r < 60)
            m = 16'($urandom_range(3, 13));
        else if (r < 95)
            m = 16'($urandom_range(2, 65535));
        else
            m = 16'($urandom_range(0, 1));
        reg_write(REG_MOD, 64'(m));
    endtask

    // Whole pattern copies, some cut short, pattern-alphabet and random noise, and an occasional end_of_text.
    function automatic int unsigned queue_text(input int unsigned n);
        int unsigned made, r, plen, cut, k;
        made = 0;
        plen = clamp_len(pat_len_reg);
        while (made < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                for (k = 0; k < plen; k++)
                    add_token(pat_byte(k), 1'b0);
                made += plen;
            end
            else if (r < 60 && plen > 1)
            begin
                cut = $urandom_range(1, plen - 1);
                for (k = 0; k < cut; k++)
                    add_token(pat_byte(k), 1'b0);
                add_token(8'($urandom), 1'b0);
                made += cut + 1;
            end
            else if (r < 90)
            begin
                cut = $urandom_range(1, 4);
                for (k = 0; k < cut; k++)
                    add_token(pat_byte($urandom_range(0, plen - 1)), 1'b0);
                made += cut;
            end
            else if (r < 96)
            begin
                cut = $urandom_range(1, 3);
                for (k = 0; k < cut; k++)
                    add_token(8'($urandom), 1'b0);
                made += cut;
            end
            else
            begin
                add_token(8'($urandom), 1'b1);
                made++;
            end
        end
        return made;
    endfunction

    // driver: bursts of transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                tokens_taken++;
                if (scan_byte(text_char, end_of_text, pending))
                    due_matches.push_back(pending);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || text_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    nxt_tok = text_queue.pop_front();
                    text_char   <= nxt_tok.ch;
                    end_of_text <= nxt_tok.eot;
                    in_valid    <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // monitor: result check and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (due_matches.size() == 0)
                begin
                    $error("unexpected result: found=%0d start=%0d total=%0d done=%0d",
                           match_found, match_start, match_total, text_done);
                    mismatches++;
                end
                else
                begin
                    want = due_matches.pop_front();
                    if (match_found !== want.found)
                    begin
                        $error("match_found: expected %0d, got %0d", want.found, match_found);
                        mismatches++;
                    end
                    if (match_start !== want.start)
                    begin
                        $error("match_start: expected %0d, got %0d", want.start, match_start);
                        mismatches++;
                    end
                    if (match_total !== want.total)
                    begin
                        $error("match_total: expected %0d, got %0d", want.total, match_total);
                        mismatches++;
                    end
                    if (text_done !== want.done)
                    begin
                        $error("text_done: expected %0d, got %0d", want.done, text_done);
                        mismatches++;
                    end
                end
            end
            // long hold while the sender still has plenty queued
            if (hold_left == 0 && results_seen >= next_hold && text_queue.size() > 20)
            begin
                hold_left = LONG_HOLD;
                next_hold += 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 3));
                    stretch_left = $urandom_range(20, 200);
                end
                else
                begin
                    stretch_left--;
                end
                rx_tick++;
                case (rx_mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= (rx_tick[3:2] == 2'd0);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned made;
        foreach (pat_word[i])
            pat_word[i] = '0;
        pat_len_reg = LEN_RESET;
        mod_reg     = MOD_RESET;
        clear_text();
        pat_hash = 0;
        lead_w   = 1;
        act_len  = 1;
        act_mod  = 32'(MOD_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero pattern of length one
        add_token(8'h00, 1'b0);
        add_token(8'hFF, 1'b0);
        add_token(8'h00, 1'b0);
        add_token(8'hA5, 1'b1);
        wait_drained();

        // length zero and modulus zero; 01 collides with FF modulo two
        reg_write(REG_LEN, 64'd0);
        reg_write(REG_MOD, 64'd0);
        reg_write(REG_PAT0, 64'h0000_0000_0000_00FF);
        add_token(8'hFF, 1'b0);
        add_token(8'h01, 1'b0);
        add_token(8'hFF, 1'b0);
        add_token(8'h00, 1'b1);
        wait_drained();

        // modulus one; text shorter than the pattern, then two hits
        reg_write(REG_MOD, 64'd1);
        reg_write(REG_LEN, 64'd3);
        reg_write(REG_PAT0, 64'h0000_0000_0062_6163);
        add_token(8'h63, 1'b0);
        add_token(8'h61, 1'b0);
        add_token(8'h00, 1'b1);
        add_token(8'h63, 1'b0);
        add_token(8'h61, 1'b0);
        add_token(8'h62, 1'b0);
        add_token(8'h63, 1'b0);
        add_token(8'h61, 1'b0);
        add_token(8'h62, 1'b0);
        add_token(8'h00, 1'b1);
        wait_drained();

        // widest modulus; settings changed mid-text keep the latched length and hash
        reg_write(REG_MOD, 64'hFFFF);
        reg_write(REG_LEN, 64'd2);
        reg_write(REG_PAT0, 64'h0000_0000_0000_FF00);
        add_token(8'h00, 1'b0);
        add_token(8'hFF, 1'b0);
        add_token(8'h00, 1'b0);
        add_token(8'hFF, 1'b0);
        wait_drained();
        reg_write(REG_PAT0, 64'd0);
        reg_write(REG_LEN, 64'd1);
        add_token(8'h00, 1'b0);
        add_token(8'hFF, 1'b0);
        add_token(8'h00, 1'b1);
        wait_drained();

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            random_config();
            made += queue_text($urandom_range(40, 90));
            if ($urandom_range(0, 1))
            begin
                add_token(8'($urandom), 1'b1);
                made++;
            end
            wait_drained();
        end

        if (tokens_taken != tokens_queued)
        begin
            $error("%0d transactions never accepted", tokens_queued - tokens_taken);
            mismatches++;
        end
        if (due_matches.size() != 0)
        begin
            $error("%0d results never arrived", due_matches.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/rhpm_pkg.sv
rtl/rhpm_mod_unit.sv
rtl/rolling_hash_pattern_match_top.sv
tb/rolling_hash_pattern_match_top_tb.sv
